@@ src/tcce_pkg.sv @@
// shared constants and codes for the text console cursor engine
package tcce_pkg;

  // default font geometry
  localparam int unsigned DefGlyphWidth  = 8;
  localparam int unsigned DefGlyphHeight = 16;
  localparam int unsigned DefFirstCode   = 32;
  localparam int unsigned DefLastCode    = 126;

  // field widths
  localparam int unsigned CoordW  = 16;
  localparam int unsigned CodeW   = 8;
  localparam int unsigned ScaleW  = 4;
  localparam int unsigned HeightW = 13;
  localparam int unsigned StatusW = 2;
  localparam int unsigned RowsW   = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 13;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 80;
  localparam int unsigned OutUserW = 4;

  // wide working width for coordinate sums
  localparam int unsigned WideW    = CoordW + 1;
  localparam int unsigned CoordMax = 32767;
  localparam int unsigned MaxScale = 15;
  localparam int unsigned TabCells = 4;

  // character codes
  localparam logic [CodeW-1:0] CharNewline = 8'd10;
  localparam logic [CodeW-1:0] CharReturn  = 8'd13;
  localparam logic [CodeW-1:0] CharTab     = 8'd9;
  localparam logic [CodeW-1:0] CharQuery   = 8'd63;

  // result status codes
  localparam logic [StatusW-1:0] StatusOk       = 2'd0;
  localparam logic [StatusW-1:0] StatusDisabled = 2'd1;
  localparam logic [StatusW-1:0] StatusBadCoord = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgEnable = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgScale  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgHeight = 2'd2;

endpackage

@@ src/tcce_rem_unit.sv @@
// bit-serial restoring remainder unit, one dividend bit per cycle
module tcce_rem_unit #(
  parameter int unsigned DividendW = 15,
  parameter int unsigned DivisorW  = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DividendW-1:0] dividend_i,
  input  logic [DivisorW-1:0]  divisor_i,
  output logic                 busy_o,
  output logic [DivisorW-1:0]  rem_o
);

  localparam int unsigned CntW = $clog2(DividendW + 1);

  logic [DividendW-1:0] shift_q, shift_d;
  logic [DivisorW-1:0]  rem_q, rem_d;
  logic [DivisorW-1:0]  dvs_q, dvs_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic [DivisorW:0]    trial;
  logic [DivisorW:0]    diff;

  assign trial = {rem_q, shift_q[DividendW-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    shift_d = shift_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    if (start_i) begin
      shift_d = dividend_i;
      rem_d   = '0;
      dvs_d   = divisor_i;
      cnt_d   = CntW'(DividendW);
      busy_d  = 1'b1;
    end else if (busy_q) begin
      shift_d = {shift_q[DividendW-2:0], 1'b0};
      // restore when the trial is below the divisor
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[DivisorW-1:0];
      end else begin
        rem_d = trial[DivisorW-1:0];
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    rem_q   <= rem_d;
    dvs_q   <= dvs_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

@@ src/text_console_cursor_engine_unit.sv @@
// text console cursor engine: cursor keeping, draw and scroll commands
// each character runs through the bit-serial tab remainder (15 remainder steps)
// and then into the result register; an output stall holds it back first.
// reset: cursor at 0,0, console disabled, scale 2, screen height 480.
// the input is taken again once the previous result is in the output register.
module text_console_cursor_engine_unit #(
  parameter int unsigned GLYPH_WIDTH  = tcce_pkg::DefGlyphWidth,
  parameter int unsigned GLYPH_HEIGHT = tcce_pkg::DefGlyphHeight,
  parameter int unsigned FIRST_CODE   = tcce_pkg::DefFirstCode,
  parameter int unsigned LAST_CODE    = tcce_pkg::DefLastCode
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // char_code[7:0], pos_x[23:8], pos_y[39:24]
  input  logic [tcce_pkg::InDataW-1:0]    s_axis_tdata,
  // use_cursor[0]
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // draw_x[15:0], draw_y[31:16], glyph_index[39:32], scroll_rows[47:40],
  // new_cursor_x[63:48], new_cursor_y[79:64]
  output logic [tcce_pkg::OutDataW-1:0]   m_axis_tdata,
  // status[1:0], draw_valid[2], scroll_valid[3]
  output logic [tcce_pkg::OutUserW-1:0]   m_axis_tuser,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tcce_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [tcce_pkg::CfgDatW-1:0]    cfg_data_i
);
  import tcce_pkg::*;

  localparam int unsigned StepMax   = GLYPH_WIDTH * TabCells * MaxScale;
  localparam int unsigned DivisorW  = $clog2(StepMax + 1);
  localparam int unsigned DividendW = CoordW - 1;

  localparam logic [0:0] StIdle = 1'b0;
  localparam logic [0:0] StRun  = 1'b1;

  logic [0:0] state_q, state_d;

  logic              en_q;
  logic [ScaleW-1:0] scale_q;
  logic [HeightW-1:0] height_q;

  logic [CoordW-1:0] col_q, col_d, row_q, row_d;

  logic [CodeW-1:0]  code_q;
  logic              use_q;
  logic [CoordW-1:0] px_q, py_q;

  logic                 div_busy;
  logic [DivisorW-1:0]  div_rem;
  logic                 start;
  logic                 finish;
  logic                 out_free;

  logic [ScaleW-1:0] scale_eff;
  logic [WideW-1:0]  cw, ch, step;
  logic [StatusW-1:0] status;
  logic              neg_x, neg_y, sel_cur;
  logic [CoordW-1:0] x, y;
  logic [WideW-1:0]  tab_sum, nl_sum, draw_sum;
  logic [CoordW-1:0] ncol, nrow;
  logic              draw, scroll;
  logic [CodeW-1:0]  sub_code, glyph;
  logic [RowsW-1:0]  srows;
  logic [WideW-1:0]  bottom_sum;

  logic               out_valid_q;
  logic [StatusW-1:0] out_status_q;
  logic               out_draw_q, out_scroll_q;
  logic [CoordW-1:0]  out_dx_q, out_dy_q, out_ncx_q, out_ncy_q;
  logic [CodeW-1:0]   out_glyph_q;
  logic [RowsW-1:0]   out_srows_q;

  function automatic logic [CoordW-1:0] sat_coord(input logic [WideW-1:0] v);
    if (v > WideW'(CoordMax)) begin
      return CoordW'(CoordMax);
    end
    return v[CoordW-1:0];
  endfunction

  // configuration registers, to be written only while idle
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q     <= 1'b0;
      scale_q  <= ScaleW'(2);
      height_q <= HeightW'(480);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgEnable: en_q     <= cfg_data_i[0];
        CfgScale:  scale_q  <= cfg_data_i[ScaleW-1:0];
        CfgHeight: height_q <= cfg_data_i[HeightW-1:0];
        default:   ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign start         = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign finish        = (state_q == StRun) && !div_busy && out_free;

  always_ff @(posedge clk_i) begin
    if (start) begin
      code_q <= s_axis_tdata[CodeW-1:0];
      px_q   <= s_axis_tdata[CodeW+CoordW-1:CodeW];
      py_q   <= s_axis_tdata[CodeW+2*CoordW-1:CodeW+CoordW];
      use_q  <= s_axis_tuser;
    end
  end

  assign scale_eff = (scale_q == '0) ? ScaleW'(1) : scale_q;
  assign cw        = WideW'(GLYPH_WIDTH) * WideW'(scale_eff);
  assign ch        = WideW'(GLYPH_HEIGHT) * WideW'(scale_eff);
  assign step      = cw << 2;

  tcce_rem_unit #(
    .DividendW(DividendW),
    .DivisorW (DivisorW)
  ) u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .dividend_i(col_q[DividendW-1:0]),
    .divisor_i (step[DivisorW-1:0]),
    .busy_o    (div_busy),
    .rem_o     (div_rem)
  );

  // result of one character from the latched item and the stored cursor
  always_comb begin
    neg_x   = px_q[CoordW-1];
    neg_y   = py_q[CoordW-1];
    sel_cur = use_q || (neg_x && neg_y);
    if (!en_q) begin
      status = StatusDisabled;
    end else if (!use_q && (neg_x != neg_y)) begin
      status = StatusBadCoord;
    end else begin
      status = StatusOk;
    end
    x = sel_cur ? col_q : px_q;
    y = sel_cur ? row_q : py_q;

    tab_sum  = WideW'(col_q) - WideW'(div_rem) + step;
    nl_sum   = WideW'(row_q) + ch;
    draw_sum = WideW'(x) + cw;

    if ((code_q < CodeW'(FIRST_CODE)) || (code_q > CodeW'(LAST_CODE))) begin
      sub_code = CharQuery;
    end else begin
      sub_code = code_q;
    end

    ncol  = col_q;
    nrow  = row_q;
    draw  = 1'b0;
    glyph = '0;
    case (code_q)
      CharNewline: begin
        ncol = '0;
        nrow = sat_coord(nl_sum);
      end
      CharReturn: ncol = '0;
      CharTab:    ncol = sat_coord(tab_sum);
      default: begin
        draw  = 1'b1;
        glyph = sub_code - CodeW'(FIRST_CODE);
        ncol  = sat_coord(draw_sum);
        nrow  = y;
      end
    endcase

    bottom_sum = WideW'(nrow) + ch;
    scroll     = bottom_sum > WideW'(height_q);
    srows      = '0;
    if (scroll) begin
      srows = (ch > WideW'(255)) ? RowsW'(255) : ch[RowsW-1:0];
      ncol  = '0;
      nrow  = (WideW'(height_q) > ch) ? CoordW'(WideW'(height_q) - ch) : '0;
    end

    if (status != StatusOk) begin
      ncol   = col_q;
      nrow   = row_q;
      draw   = 1'b0;
      glyph  = '0;
      scroll = 1'b0;
      srows  = '0;
    end
  end

  assign col_d = finish ? ncol : col_q;
  assign row_d = finish ? nrow : row_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (start) state_d = StRun;
      StRun:   if (finish) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_status_q <= status;
      out_draw_q   <= draw;
      out_scroll_q <= scroll;
      out_dx_q     <= draw ? x : '0;
      out_dy_q     <= draw ? y : '0;
      out_glyph_q  <= glyph;
      out_srows_q  <= srows;
      out_ncx_q    <= ncol;
      out_ncy_q    <= nrow;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_ncy_q, out_ncx_q, out_srows_q, out_glyph_q, out_dy_q, out_dx_q};
  assign m_axis_tuser  = {out_scroll_q, out_draw_q, out_status_q};

endmodule

@@ src/tcce_checker.sv @@
// port-level checks for the text console cursor engine
module tcce_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [tcce_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [tcce_pkg::OutUserW-1:0] m_axis_tuser
);
  import tcce_pkg::*;

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // one character at a time: no new transaction right after one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  // a rejected character produces no command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[1:0] != StatusOk) |-> (m_axis_tuser[3:2] == 2'b00))
    else $error("command on a rejected character");

  // a scroll always moves by a nonzero height and homes the column
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[3] |-> (m_axis_tdata[47:40] != '0)
      && (m_axis_tdata[63:48] == '0))
    else $error("bad scroll result");

  // a draw without scroll leaves the cursor on the glyph's row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2] && !m_axis_tuser[3]
      |-> (m_axis_tdata[79:64] == m_axis_tdata[31:16]))
    else $error("cursor row differs from drawn row");

endmodule

bind text_console_cursor_engine_unit tcce_checker u_tcce_checker (.*);

@@ test/tb_text_console_cursor_engine_unit.sv @@
// self-checking testbench for the text console cursor engine: random stream traffic vs a predictor
module tb_text_console_cursor_engine_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import tcce_pkg::*;

  localparam int CycleLimit = 600_000;
  localparam int SettleCycles = 3;
  localparam int TailCycles = 40;

  typedef struct packed {
    logic [CodeW-1:0]         code;
    logic                     use_cur;
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
  } char_item_t;

  typedef struct packed {
    logic                     is_cfg;
    logic [CfgIdxW-1:0]       idx;
    logic [CfgDatW-1:0]       data;
    char_item_t               chr;
  } feed_entry_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic               draw;
    logic [CoordW-1:0]  dx;
    logic [CoordW-1:0]  dy;
    logic [CodeW-1:0]   glyph;
    logic               scroll;
    logic [RowsW-1:0]   srows;
    logic [CoordW-1:0]  ncx;
    logic [CoordW-1:0]  ncy;
  } console_cmd_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // char_code[7:0], pos_x[23:8], pos_y[39:24]
  logic [InDataW-1:0]  s_axis_tdata = '0;
  // use_cursor[0]
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // draw_x[15:0], draw_y[31:16], glyph_index[39:32], scroll_rows[47:40],
  // new_cursor_x[63:48], new_cursor_y[79:64]
  logic [OutDataW-1:0] m_axis_tdata;
  // status[1:0], draw_valid[2], scroll_valid[3]
  logic [OutUserW-1:0] m_axis_tuser;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDatW-1:0]  cfg_data_i = '0;

  text_console_cursor_engine_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // predictor copy of registers and cursor
  logic      console_on = 1'b0;
  int        glyph_scale = 2;
  int        screen_rows = 480;
  int        cursor_col = 0;
  int        cursor_row = 0;

  feed_entry_t  char_feed[$];
  console_cmd_t predicted_cmds[$];
  char_item_t   held_char;
  feed_entry_t  held_cfg;

  int err_cnt = 0;
  int cycle_cnt = 0;
  int chars_sent = 0;
  int cfg_writes = 0;
  int cmds_seen = 0;
  int draws_seen = 0;
  int scrolls_seen = 0;
  int disabled_seen = 0;
  int badcoord_seen = 0;
  int gap_cnt = 0;
  int drv_calm = 0;
  int quiet_cnt = 0;
  int stall_cnt = 0;
  int mon_calm = 0;

  function automatic int clamp_coord(int v);
    if (v > int'(CoordMax)) return int'(CoordMax);
    if (v < 0) return 0;
    return v;
  endfunction

  // works out the command for one character and moves the cursor
  function automatic console_cmd_t advance_cursor(char_item_t it);
    console_cmd_t r;
    int scl, cw, ch, x, y, px, py, tab_step;
    logic [CodeW-1:0] c;
    r = '0;
    px = int'(it.px);
    py = int'(it.py);
    scl = (glyph_scale == 0) ? 1 : glyph_scale;
    cw = int'(DefGlyphWidth) * scl;
    ch = int'(DefGlyphHeight) * scl;
    if (!console_on) r.status = StatusDisabled;
    else if (!it.use_cur && ((px < 0) != (py < 0))) r.status = StatusBadCoord;
    else r.status = StatusOk;
    if (r.status == StatusOk) begin
      if (it.use_cur || (px < 0 && py < 0)) begin
        x = cursor_col;
        y = cursor_row;
      end else begin
        x = px;
        y = py;
      end
      case (it.code)
        CharNewline: begin
          cursor_col = 0;
          cursor_row = clamp_coord(cursor_row + ch);
        end
        CharReturn: begin
          cursor_col = 0;
        end
        CharTab: begin
          tab_step = cw * int'(TabCells);
          cursor_col = clamp_coord((cursor_col / tab_step + 1) * tab_step);
        end
        default: begin
          c = it.code;
          if (c < DefFirstCode || c > DefLastCode) c = CharQuery;
          r.glyph = CodeW'(c - DefFirstCode);
          r.draw = 1'b1;
          r.dx = CoordW'(x);
          r.dy = CoordW'(y);
          cursor_col = clamp_coord(x + cw);
          cursor_row = y;
        end
      endcase
      if (cursor_row + ch > screen_rows) begin
        r.scroll = 1'b1;
        r.srows = RowsW'((ch > 255) ? 255 : ch);
        cursor_col = 0;
        cursor_row = clamp_coord(screen_rows - ch);
      end
    end
    r.ncx = CoordW'(cursor_col);
    r.ncy = CoordW'(cursor_row);
    return r;
  endfunction

  // mostly short gaps, a few long ones, and now and then a stretch with none
  function automatic int pick_gap(inout int calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if (roll < 4) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(string msg);
    err_cnt++;
    if (err_cnt <= 50) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s got %0d want %0d", cmds_seen, name, got, want));
  endtask

  task automatic push_char(int code, bit uc, int px, int py);
    feed_entry_t e;
    e = '0;
    e.chr.code = CodeW'(code);
    e.chr.use_cur = uc;
    e.chr.px = CoordW'(px);
    e.chr.py = CoordW'(py);
    char_feed.push_back(e);
  endtask

  task automatic push_cfg(logic [CfgIdxW-1:0] idx, int value);
    feed_entry_t e;
    e = '0;
    e.is_cfg = 1'b1;
    e.idx = idx;
    e.data = CfgDatW'(value);
    char_feed.push_back(e);
  endtask

  function automatic int rand_neg();
    return -1 - int'($urandom_range(0, 32767));
  endfunction

  // driver: presents characters and register writes in feed order
  always @(posedge clk_i) begin : driver
    feed_entry_t nxt;
    logic v_next, c_next;
    v_next = s_axis_tvalid;
    c_next = cfg_valid_i;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predicted_cmds.push_back(advance_cursor(held_char));
        chars_sent++;
        v_next = 1'b0;
        gap_cnt = pick_gap(drv_calm);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (held_cfg.idx)
          CfgEnable: console_on = held_cfg.data[0];
          CfgScale:  glyph_scale = int'(held_cfg.data[ScaleW-1:0]);
          CfgHeight: screen_rows = int'(held_cfg.data[HeightW-1:0]);
          default: ;
        endcase
        cfg_writes++;
        c_next = 1'b0;
      end
      if (predicted_cmds.size() == 0 && !v_next) quiet_cnt++;
      else quiet_cnt = 0;
      if (!v_next && !c_next && char_feed.size() > 0) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
        end else if (!char_feed[0].is_cfg) begin
          nxt = char_feed.pop_front();
          held_char = nxt.chr;
          s_axis_tdata <= {nxt.chr.py, nxt.chr.px, nxt.chr.code};
          s_axis_tuser <= nxt.chr.use_cur;
          v_next = 1'b1;
        end else if (quiet_cnt >= SettleCycles) begin
          // registers only change with nothing in flight
          nxt = char_feed.pop_front();
          held_cfg = nxt;
          cfg_index_i <= nxt.idx;
          cfg_data_i <= nxt.data;
          c_next = 1'b1;
        end
      end
    end
    s_axis_tvalid <= v_next;
    cfg_valid_i <= c_next;
  end

  // monitor: takes results with random backpressure and checks them
  always @(posedge clk_i) begin : monitor
    console_cmd_t got, want;
    logic hs;
    hs = m_axis_tvalid && m_axis_tready;
    if (rst_ni) begin
      if (hs) begin
        got.dx = m_axis_tdata[15:0];
        got.dy = m_axis_tdata[31:16];
        got.glyph = m_axis_tdata[39:32];
        got.srows = m_axis_tdata[47:40];
        got.ncx = m_axis_tdata[63:48];
        got.ncy = m_axis_tdata[79:64];
        got.status = m_axis_tuser[1:0];
        got.draw = m_axis_tuser[2];
        got.scroll = m_axis_tuser[3];
        cmds_seen++;
        if (predicted_cmds.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing pending", cmds_seen));
        end else begin
          want = predicted_cmds.pop_front();
          check_field("status", got.status, want.status);
          check_field("draw_valid", got.draw, want.draw);
          check_field("draw_x", got.dx, want.dx);
          check_field("draw_y", got.dy, want.dy);
          check_field("glyph_index", got.glyph, want.glyph);
          check_field("scroll_valid", got.scroll, want.scroll);
          check_field("scroll_rows", got.srows, want.srows);
          check_field("new_cursor_x", got.ncx, want.ncx);
          check_field("new_cursor_y", got.ncy, want.ncy);
        end
        if (got.draw) draws_seen++;
        if (got.scroll) scrolls_seen++;
        if (got.status == StatusDisabled) disabled_seen++;
        if (got.status == StatusBadCoord) badcoord_seen++;
      end
      if (stall_cnt > 0) stall_cnt--;
      else if (hs || $urandom_range(0, 5) == 0) stall_cnt = pick_gap(mon_calm);
      m_axis_tready <= (stall_cnt == 0);
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_cnt, predicted_cmds.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int ph, n, roll, code, px, py, rows_now, phase_items;
    bit uc;

    // character while the console is still off after reset
    push_char("A", 1'b1, 0, 0);
    push_cfg(CfgEnable, 1);
    push_char("A", 1'b1, 0, 0);
    push_char(DefFirstCode, 1'b1, 0, 0);
    push_char(DefLastCode, 1'b0, 100, 200);
    push_char(127, 1'b1, 0, 0);
    push_char(0, 1'b0, -1, -32768);
    push_char(255, 1'b0, -5, 10);
    push_char(65, 1'b0, 10, -32768);
    push_char("m", 1'b1, -1, 5);
    push_char(CharTab, 1'b0, 0, 0);
    push_char(CharReturn, 1'b0, 0, 0);
    push_char(CharNewline, 1'b0, 300, 300);
    // far corner: column and row saturate, then the row scrolls back
    push_char("B", 1'b0, 32767, 32767);
    push_char("C", 1'b0, 32760, 0);
    push_char(CharTab, 1'b1, 0, 0);
    push_char("x", 1'b0, 0, 448);
    push_char(CharNewline, 1'b1, 0, 0);
    push_char(31, 1'b1, 0, 0);
    // scale 0 acts as 1
    push_cfg(CfgScale, 0);
    push_cfg(CfgHeight, 16);
    push_char("A", 1'b1, 0, 0);
    push_char(CharTab, 1'b1, 0, 0);
    // cell taller than the screen
    push_cfg(CfgScale, 8);
    push_char("Z", 1'b1, 0, 0);
    push_char(CharNewline, 1'b1, 0, 0);

    for (ph = 0; ph < 11; ph++) begin
      case (ph)
        0: rows_now = 4096;
        1: rows_now = 16;
        2: rows_now = 480;
        default: rows_now = $urandom_range(16, 4096);
      endcase
      push_cfg(CfgEnable, (ph == 4) ? 0 : 1);
      case (ph)
        0: push_cfg(CfgScale, 0);
        1: push_cfg(CfgScale, 8);
        2: push_cfg(CfgScale, 1);
        default: push_cfg(CfgScale, $urandom_range(0, 8));
      endcase
      push_cfg(CfgHeight, rows_now);
      phase_items = (ph == 4) ? 20 : 73;
      for (n = 0; n < phase_items; n++) begin
        roll = $urandom_range(0, 99);
        uc = 1'b0;
        px = 0;
        py = 0;
        if (roll < 55) begin
          // running text from the stored cursor
          code = $urandom_range(DefFirstCode, DefLastCode);
          if ($urandom_range(0, 1)) begin
            uc = 1'b1;
            px = $urandom_range(0, 65535) - 32768;
            py = $urandom_range(0, 65535) - 32768;
          end else begin
            px = rand_neg();
            py = rand_neg();
          end
        end else if (roll < 70) begin
          case ($urandom_range(0, 3))
            0, 1: code = CharNewline;
            2: code = CharReturn;
            default: code = CharTab;
          endcase
          uc = $urandom_range(0, 1);
          px = $urandom_range(0, 65535) - 32768;
          py = $urandom_range(0, 65535) - 32768;
        end else if (roll < 82) begin
          code = $urandom_range(0, 255);
          px = $urandom_range(0, 32767);
          py = $urandom_range(0, 1) ? $urandom_range(0, rows_now + 64) : $urandom_range(0, 32767);
        end else if (roll < 90) begin
          // exactly one coordinate omitted
          code = $urandom_range(0, 255);
          if ($urandom_range(0, 1)) begin
            px = rand_neg();
            py = $urandom_range(0, 32767);
          end else begin
            px = $urandom_range(0, 32767);
            py = rand_neg();
          end
        end else begin
          code = $urandom_range(0, 255);
          uc = $urandom_range(0, 1);
          px = $urandom_range(0, 65535);
          py = $urandom_range(0, 65535);
        end
        push_char(code, uc, px, py);
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (char_feed.size() != 0 || s_axis_tvalid || cfg_valid_i || predicted_cmds.size() != 0)
      @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (predicted_cmds.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", predicted_cmds.size()));

    $display("%0d characters and %0d register writes sent, %0d results checked",
             chars_sent, cfg_writes, cmds_seen);
    $display("results: %0d draws, %0d scrolls, %0d rejected while off, %0d bad coordinates",
             draws_seen, scrolls_seen, disabled_seen, badcoord_seen);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
